@@ src/assert_macros.svh @@
// Assertion helper macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked implication check, disabled while reset is asserted.
`define CHK_IMPLY(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Clocked check that also holds during reset.
`define CHK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

@@ src/rha_pkg.sv @@
// ----------------------------------------------------------------------------
// rha_pkg
// Shared types and constants for the reference-counted handle allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package rha_pkg;
    localparam int MEM_BYTES_DEF   = 65536;
    localparam int MAX_OBJECTS_DEF = 32;

    localparam logic [1:0] MODE_ALLOC  = 2'd0;
    localparam logic [1:0] MODE_RETR   = 2'd1;
    localparam logic [1:0] MODE_ADD    = 2'd2;
    localparam logic [1:0] MODE_DROP   = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    localparam logic KIND_COPY  = 1'b0;
    localparam logic KIND_REPLY = 1'b1;

    typedef struct packed {
        logic [31:0] handle;
        logic [15:0] start;
        logic [15:0] size;
        logic [15:0] refs;
    } entry_t;

    // command broadcast from the controller to every cell
    typedef enum logic [2:0] {
        OP_NONE,
        OP_MATCH,
        OP_INC,
        OP_DEC,
        OP_REMOVE,
        OP_SHIFT,
        OP_WRITE
    } cell_op_t;

    typedef struct packed {
        cell_op_t    op;
        logic [31:0] key;
        entry_t      wdata;
        logic [5:0]  widx;
    } cell_cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_ACT,
        S_COMPACT,
        S_ALLOC,
        S_REPLY
    } state_t;
endpackage
`default_nettype wire

@@ src/rha_cell.sv @@
// ----------------------------------------------------------------------------
// rha_cell
// One table slot: holds an entry, compares its handle, shifts toward
// lower slots on removal and rotates toward lower slots during compaction.
// ----------------------------------------------------------------------------
`default_nettype none
module rha_cell #(
    parameter int IDX_W = 6,
    parameter int POS   = 0
) (
    input  wire              clk,
    input  wire rha_pkg::cell_cmd_t cmd,
    input  wire [IDX_W-1:0]  live,
    input  wire              below_hit,   // a lower slot matched
    input  wire rha_pkg::entry_t from_up, // neighbor above
    input  wire              rot_start_we,
    input  wire [15:0]       rot_start,
    output rha_pkg::entry_t  q,
    output logic             hit
);
    rha_pkg::entry_t ent_reg;
    rha_pkg::entry_t shift_ent;
    logic            hit_reg;
    logic            in_use;

    assign in_use = (IDX_W'(POS) < live);
    assign q      = ent_reg;
    assign hit    = hit_reg;

    // rotate: slot 0 content travels to the top live slot with its new start
    always_comb
    begin
        shift_ent = from_up;
        if (rot_start_we)
            shift_ent.start = rot_start;
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            rha_pkg::OP_MATCH:
                hit_reg <= in_use && (ent_reg.handle == cmd.key) && (cmd.key != 32'd0);
            rha_pkg::OP_INC:
                if (hit_reg && ent_reg.refs != 16'hFFFF)
                    ent_reg.refs <= ent_reg.refs + 16'd1;
            rha_pkg::OP_DEC:
                if (hit_reg)
                    ent_reg.refs <= ent_reg.refs - 16'd1;
            rha_pkg::OP_REMOVE:
            begin
                if (hit_reg || below_hit)
                    ent_reg <= from_up;
                hit_reg <= 1'b0;
            end
            rha_pkg::OP_SHIFT:
                ent_reg <= shift_ent;
            rha_pkg::OP_WRITE:
                if (cmd.widx == 6'(POS))
                    ent_reg <= cmd.wdata;
            default: ;
        endcase
    end
endmodule
`default_nettype wire

@@ src/refcounted_handle_allocator.sv @@
// ----------------------------------------------------------------------------
// refcounted_handle_allocator
// Handle table in a row of cells with two-buffer compaction.
// ----------------------------------------------------------------------------
// channel   | direction | handshake         | payload
// request   | in        | start & !busy     | mode, size, handle
// result    | out       | strobe (1 cycle)  | kind, status, result_handle,
//           |           |                   | buffer_select, address,
//           |           |                   | copy_source, copy_length, last
//
// Retrieve/add/drop: after acceptance, match in the cells, then act, with
// the reply registered as the act is done.
// Allocate: match, act, then write with the reply. Compaction adds one step per
// live entry plus a wrap-up and a refit check; each compaction step rotates
// the row by one cell and emits one copy transaction. A request that still
// does not fit replies from the refit check instead of writing.
// Reset clears counters and control; the table needs none.
// Results cannot be stalled; busy drops as the final reply goes out.
// ----------------------------------------------------------------------------
`default_nettype none
module refcounted_handle_allocator #(
    parameter int MEM_BYTES   = rha_pkg::MEM_BYTES_DEF,
    parameter int MAX_OBJECTS = rha_pkg::MAX_OBJECTS_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [1:0]  mode,
    input  wire  [15:0] size,
    input  wire  [31:0] handle,
    output logic        strobe,
    output logic        kind,
    output logic [1:0]  status,
    output logic [31:0] result_handle,
    output logic        buffer_select,
    output logic [15:0] address,
    output logic [15:0] copy_source,
    output logic [15:0] copy_length,
    output logic        last
);
    localparam int IDX_W = 6;
    localparam logic [16:0] MEMB = 17'(MEM_BYTES);

    rha_pkg::state_t state_reg, state_next;
    logic [1:0]  mode_reg;
    logic [15:0] size_reg;
    logic [31:0] key_reg;
    logic [IDX_W-1:0] live_reg, live_next;
    logic [16:0] free_reg, free_next;      // 17 bits so off+size wraps as in mod 2^17
    logic [31:0] nh_reg, nh_next;
    logic        buf_reg, buf_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;

    logic        o_stb_next, o_kind_next, o_bsel_next, o_last_next;
    logic [1:0]  o_st_next;
    logic [31:0] o_rh_next;
    logic [15:0] o_addr_next, o_src_next, o_len_next;

    rha_pkg::cell_cmd_t cmd;
    rha_pkg::entry_t q [MAX_OBJECTS];
    rha_pkg::entry_t up [MAX_OBJECTS];
    logic [MAX_OBJECTS-1:0] hits;
    logic [MAX_OBJECTS-1:0] below;
    logic        any_hit;
    logic [15:0] hit_refs;
    logic [15:0] hit_start;
    logic        rot_we;

    // Neighbor wiring: in rotate, the top live cell takes slot 0.
    always_comb
    begin
        below[0] = 1'b0;
        for (int i = 1; i < MAX_OBJECTS; i++)
            below[i] = below[i-1] | hits[i-1];
        for (int i = 0; i < MAX_OBJECTS; i++)
        begin
            if (cmd.op == rha_pkg::OP_SHIFT && IDX_W'(i + 1) == live_reg)
                up[i] = q[0];
            else if (i + 1 < MAX_OBJECTS)
                up[i] = q[(i + 1) % MAX_OBJECTS];
            else
                up[i] = q[i];
        end
    end

    // hit mux is one-hot (handles unique)
    always_comb
    begin
        hit_refs  = '0;
        hit_start = '0;
        for (int i = 0; i < MAX_OBJECTS; i++)
            if (hits[i])
            begin
                hit_refs  = hit_refs | q[i].refs;
                hit_start = hit_start | q[i].start;
            end
        any_hit = |hits;
    end

    genvar g;
    generate
        for (g = 0; g < MAX_OBJECTS; g++)
        begin : g_cell
            rha_cell #(.IDX_W(IDX_W), .POS(g)) u_cell (
                .clk(clk), .cmd(cmd), .live(live_reg),
                .below_hit(below[g]), .from_up(up[g]),
                .rot_start_we(rot_we && IDX_W'(g + 1) == live_reg),
                .rot_start(free_reg[15:0]),
                .q(q[g]), .hit(hits[g]));
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rha_pkg::S_IDLE;
            live_reg  <= '0;
            free_reg  <= '0;
            nh_reg    <= 32'd1;
            buf_reg   <= 1'b0;
            cnt_reg   <= '0;
            strobe    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            live_reg  <= live_next;
            free_reg  <= free_next;
            nh_reg    <= nh_next;
            buf_reg   <= buf_next;
            cnt_reg   <= cnt_next;
            strobe    <= o_stb_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            mode_reg <= mode;
            size_reg <= size;
            key_reg  <= handle;
        end
        kind          <= o_kind_next;
        status        <= o_st_next;
        result_handle <= o_rh_next;
        buffer_select <= o_bsel_next;
        address       <= o_addr_next;
        copy_source   <= o_src_next;
        copy_length   <= o_len_next;
        last          <= o_last_next;
    end

    assign busy = (state_reg != rha_pkg::S_IDLE);

    always_comb
    begin
        logic fits;
        fits = ({1'b0, size_reg} < (MEMB - {1'b0, free_reg[15:0]}));
        state_next = state_reg;
        live_next  = live_reg;
        free_next  = free_reg;
        nh_next    = nh_reg;
        buf_next   = buf_reg;
        cnt_next   = cnt_reg;
        cmd.op     = rha_pkg::OP_NONE;
        cmd.key    = key_reg;
        cmd.widx   = live_reg;
        cmd.wdata  = '{handle: nh_reg, start: free_reg[15:0], size: size_reg,
                       refs: 16'd1};
        rot_we     = 1'b0;
        o_stb_next = 1'b0;
        o_kind_next = rha_pkg::KIND_REPLY;
        o_st_next  = rha_pkg::ST_OK;
        o_rh_next  = '0;
        o_bsel_next = 1'b0;
        o_addr_next = '0;
        o_src_next = '0;
        o_len_next = '0;
        o_last_next = 1'b1;
        unique case (state_reg)
            rha_pkg::S_IDLE:
                if (start)
                    state_next = rha_pkg::S_LOOKUP;
            rha_pkg::S_LOOKUP:
            begin
                cmd.op = rha_pkg::OP_MATCH;
                state_next = rha_pkg::S_ACT;
                cnt_next = '0;
            end
            rha_pkg::S_ACT:
            begin
                state_next = rha_pkg::S_IDLE;
                o_stb_next = 1'b1;
                if (mode_reg == rha_pkg::MODE_ALLOC)
                begin
                    if (32'(live_reg) >= 32'(MAX_OBJECTS) || nh_reg == 32'd0)
                        o_st_next = rha_pkg::ST_FULL;
                    else if (size_reg == 16'd0)
                        o_st_next = rha_pkg::ST_NOSPACE;
                    else
                    begin
                        o_stb_next = 1'b0;
                        if (fits)
                            state_next = rha_pkg::S_ALLOC;
                        else
                        begin
                            state_next = rha_pkg::S_COMPACT;
                            free_next = '0;
                        end
                    end
                end
                else if (!any_hit)
                    o_st_next = rha_pkg::ST_UNKNOWN;
                else if (mode_reg == rha_pkg::MODE_RETR)
                begin
                    o_bsel_next = buf_reg;
                    o_addr_next = hit_start;
                end
                else if (mode_reg == rha_pkg::MODE_ADD)
                    cmd.op = rha_pkg::OP_INC;
                else if (hit_refs == 16'd1)
                begin
                    cmd.op = rha_pkg::OP_REMOVE;
                    live_next = live_reg - 1'b1;
                end
                else
                    cmd.op = rha_pkg::OP_DEC;
            end
            rha_pkg::S_COMPACT:
            begin
                if (cnt_reg == live_reg)
                begin
                    buf_next = ~buf_reg;
                    free_next = {1'b0, free_reg[15:0]};
                    state_next = rha_pkg::S_REPLY;
                end
                else
                begin
                    cmd.op = rha_pkg::OP_SHIFT;
                    rot_we = 1'b1;
                    o_stb_next = 1'b1;
                    o_kind_next = rha_pkg::KIND_COPY;
                    o_last_next = 1'b0;
                    o_bsel_next = ~buf_reg;
                    o_addr_next = free_reg[15:0];
                    o_src_next = q[0].start;
                    o_len_next = q[0].size;
                    free_next = free_reg + {1'b0, q[0].size};
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            rha_pkg::S_REPLY:
            begin
                if (fits)
                    state_next = rha_pkg::S_ALLOC;
                else
                begin
                    o_stb_next = 1'b1;
                    o_st_next = rha_pkg::ST_NOSPACE;
                    state_next = rha_pkg::S_IDLE;
                end
            end
            rha_pkg::S_ALLOC:
            begin
                cmd.op = rha_pkg::OP_WRITE;
                live_next = live_reg + 1'b1;
                nh_next = nh_reg + 32'd1;
                free_next = {1'b0, free_reg[15:0] + size_reg};
                o_stb_next = 1'b1;
                o_rh_next = nh_reg;
                o_bsel_next = buf_reg;
                o_addr_next = free_reg[15:0];
                o_len_next = size_reg;
                state_next = rha_pkg::S_IDLE;
            end
            default:
                state_next = rha_pkg::S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

@@ src/rha_checker.sv @@
// ----------------------------------------------------------------------------
// rha_checker
// Port-level checks on the allocator's result stream and request handshake.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module rha_checker (
    input wire clk,
    input wire rst_n,
    input wire start,
    input wire busy,
    input wire strobe,
    input wire kind,
    input wire last,
    input wire [1:0] status
);
    `CHK_IMPLY(a_last_kind, clk, rst_n, strobe |-> (last == kind), "last must match kind")
    `CHK_IMPLY(a_copy_ok, clk, rst_n, (strobe && !kind) |-> status == rha_pkg::ST_OK, "copy status")
    `CHK_IMPLY(a_reply_frees, clk, rst_n, (strobe && last) |-> !busy, "busy after reply")
    `CHK_IMPLY(a_accept_busy, clk, rst_n, (start && !busy) |=> busy, "busy after accept")
endmodule
bind refcounted_handle_allocator rha_checker u_rha_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .strobe(strobe),
    .kind(kind), .last(last), .status(status));
`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the reference-counted handle allocator: directed
// table of requests, then random bursts of mostly valid-handle requests,
// with every copy and reply transaction checked against a local table model.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
    localparam int NOBJ = rha_pkg::MAX_OBJECTS_DEF;
    localparam int MEMB = rha_pkg::MEM_BYTES_DEF;

    // one result transaction
    typedef struct packed {
        logic        kind;
        logic [1:0]  status;
        logic [31:0] rhandle;
        logic        bsel;
        logic [15:0] addr;
        logic [15:0] src;
        logic [15:0] len;
        logic        last;
    } res_t;

    // one row of the directed table; chk set means exp is typed in by hand
    typedef struct {
        logic [1:0]  mode;
        logic [15:0] size;
        logic [31:0] handle;
        bit          chk;
        res_t        exp;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  mode;
    logic [15:0] size;
    logic [31:0] handle;
    logic        strobe;
    logic        kind;
    logic [1:0]  status;
    logic [31:0] result_handle;
    logic        buffer_select;
    logic [15:0] address;
    logic [15:0] copy_source;
    logic [15:0] copy_length;
    logic        last;

    refcounted_handle_allocator u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .mode(mode), .size(size), .handle(handle),
        .strobe(strobe), .kind(kind), .status(status),
        .result_handle(result_handle), .buffer_select(buffer_select),
        .address(address), .copy_source(copy_source),
        .copy_length(copy_length), .last(last)
    );

    // mirror of the block's table
    logic [31:0] tbl_handle [NOBJ];
    logic [15:0] tbl_start  [NOBJ];
    logic [15:0] tbl_size   [NOBJ];
    logic [15:0] tbl_refs   [NOBJ];
    int          tbl_live;
    logic [15:0] tbl_free;
    logic [31:0] tbl_next;
    logic        tbl_buf;

    res_t pending_results [$];
    int   errors;
    int   n_items;
    int   n_results;
    int   n_copies;
    int   n_compactions;

    function automatic res_t reply(logic [1:0] st, logic [31:0] rh, logic b,
                                   logic [15:0] a, logic [15:0] l);
        res_t r;
        r = '{rha_pkg::KIND_REPLY, st, rh, b, a, 16'd0, l, 1'b1};
        return r;
    endfunction

    function automatic int find_entry(logic [31:0] h);
        if (h == 32'd0)
            return -1;
        for (int i = 0; i < tbl_live; i++)
            if (tbl_handle[i] == h)
                return i;
        return -1;
    endfunction

    // Predict all transactions for one request and update the mirror.
    task automatic predict_request(logic [1:0] md, logic [15:0] sz, logic [31:0] h);
        int          idx;
        logic [16:0] off;
        res_t        r;
        if (md == rha_pkg::MODE_ALLOC) begin
            if (tbl_live >= NOBJ || tbl_next == 32'd0) begin
                pending_results.push_back(reply(rha_pkg::ST_FULL, 0, 0, 0, 0));
                return;
            end
            if (sz == 16'd0) begin
                pending_results.push_back(reply(rha_pkg::ST_NOSPACE, 0, 0, 0, 0));
                return;
            end
            if (32'(sz) >= MEMB - 32'(tbl_free)) begin
                // compaction into the other buffer, one copy per live entry
                n_compactions++;
                off = 17'd0;
                for (int i = 0; i < tbl_live; i++) begin
                    r = '{rha_pkg::KIND_COPY, rha_pkg::ST_OK, 32'd0, ~tbl_buf, off[15:0],
                          tbl_start[i], tbl_size[i], 1'b0};
                    pending_results.push_back(r);
                    tbl_start[i] = off[15:0];
                    off = off + 17'(tbl_size[i]);
                end
                tbl_free = off[15:0];
                tbl_buf = ~tbl_buf;
            end
            if (32'(sz) >= MEMB - 32'(tbl_free)) begin
                pending_results.push_back(reply(rha_pkg::ST_NOSPACE, 0, 0, 0, 0));
                return;
            end
            tbl_handle[tbl_live] = tbl_next;
            tbl_start[tbl_live]  = tbl_free;
            tbl_size[tbl_live]   = sz;
            tbl_refs[tbl_live]   = 16'd1;
            tbl_live++;
            pending_results.push_back(reply(rha_pkg::ST_OK, tbl_next, tbl_buf, tbl_free, sz));
            tbl_next = tbl_next + 32'd1;
            tbl_free = tbl_free + sz;
            return;
        end
        idx = find_entry(h);
        if (idx < 0) begin
            pending_results.push_back(reply(rha_pkg::ST_UNKNOWN, 0, 0, 0, 0));
            return;
        end
        case (md)
            rha_pkg::MODE_RETR:
                pending_results.push_back(reply(rha_pkg::ST_OK, 0, tbl_buf,
                                                tbl_start[idx], 0));
            rha_pkg::MODE_ADD:
            begin
                if (tbl_refs[idx] != 16'hFFFF)
                    tbl_refs[idx]++;
                pending_results.push_back(reply(rha_pkg::ST_OK, 0, 0, 0, 0));
            end
            default:
            begin
                tbl_refs[idx]--;
                if (tbl_refs[idx] == 16'd0) begin
                    // remove in order
                    for (int i = idx; i + 1 < tbl_live; i++) begin
                        tbl_handle[i] = tbl_handle[i + 1];
                        tbl_start[i]  = tbl_start[i + 1];
                        tbl_size[i]   = tbl_size[i + 1];
                        tbl_refs[i]   = tbl_refs[i + 1];
                    end
                    tbl_live--;
                end
                pending_results.push_back(reply(rha_pkg::ST_OK, 0, 0, 0, 0));
            end
        endcase
    endtask

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: worst case is well under this.
    initial begin
        #20ms;
        $display("refcounted_handle_allocator regression: fail");
        $finish;
    end

    // Result monitor: the block cannot be stalled, so sample every strobe.
    always @(posedge clk) begin
        res_t got;
        res_t want;
        if (rst_n && strobe) begin
            got = '{kind, status, result_handle, buffer_select, address,
                    copy_source, copy_length, last};
            n_results++;
            if (kind == rha_pkg::KIND_COPY)
                n_copies++;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %h", $time, got);
            end else begin
                want = pending_results.pop_front();
                if (got.kind != want.kind)
                    $display("%0t: kind exp %h got %h", $time, want.kind, got.kind);
                if (got.status != want.status)
                    $display("%0t: status exp %h got %h", $time, want.status, got.status);
                if (got.rhandle != want.rhandle)
                    $display("%0t: handle exp %h got %h", $time, want.rhandle, got.rhandle);
                if (got.bsel != want.bsel)
                    $display("%0t: buffer exp %h got %h", $time, want.bsel, got.bsel);
                if (got.addr != want.addr)
                    $display("%0t: address exp %h got %h", $time, want.addr, got.addr);
                if (got.src != want.src)
                    $display("%0t: source exp %h got %h", $time, want.src, got.src);
                if (got.len != want.len)
                    $display("%0t: length exp %h got %h", $time, want.len, got.len);
                if (got.last != want.last)
                    $display("%0t: last exp %h got %h", $time, want.last, got.last);
                if (got != want)
                    errors++;
            end
        end
    end

    // Present one request and hold it until accepted. If chk is set the
    // typed-in reply must agree with the predictor. start stays high after
    // acceptance; the caller drops it when it pauses.
    task automatic issue(logic [1:0] md, logic [15:0] sz, logic [31:0] h,
                         bit chk = 0, res_t want = '0);
        start  <= 1'b1;
        mode   <= md;
        size   <= sz;
        handle <= h;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // accepted at this edge
        predict_request(md, sz, h);
        n_items++;
        if (chk && pending_results[$] != want) begin
            errors++;
            $display("%0t: table row exp %h predicted %h", $time, want,
                     pending_results[$]);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // pick a handle: mostly live, sometimes the next unissued one, null or random
    function automatic logic [31:0] pick_handle();
        int r;
        r = $urandom_range(0, 9);
        if (tbl_live != 0 && r < 7)
            return tbl_handle[$urandom_range(0, tbl_live - 1)];
        if (r == 7)
            return 32'd0;
        if (r == 8)
            return tbl_next;
        return $urandom;
    endfunction

    function automatic logic [15:0] pick_size();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return 16'($urandom_range(1, 4000));
        if (r < 8)
            return 16'($urandom_range(8000, 30000));
        if (r == 8)
            return 16'hFFFF;
        return 16'($urandom);
    endfunction

    row_t dir_rows [$];

    initial begin
        logic [1:0] md;
        int         burst;
        errors = 0; n_items = 0; n_results = 0; n_copies = 0; n_compactions = 0;
        tbl_live = 0; tbl_free = 16'd0; tbl_next = 32'd1; tbl_buf = 1'b0;
        rst_n = 1'b0; start = 1'b0; mode = rha_pkg::MODE_ALLOC; size = 16'd0;
        handle = 32'd0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, zero size, extremes, saturation, compaction
        dir_rows = '{
            '{rha_pkg::MODE_RETR,  16'd0,    32'd1,        1,
              reply(rha_pkg::ST_UNKNOWN, 0, 0, 0, 0)},
            '{rha_pkg::MODE_ADD,   16'd0,    32'd0,        1,
              reply(rha_pkg::ST_UNKNOWN, 0, 0, 0, 0)},
            '{rha_pkg::MODE_DROP,  16'hFFFF, 32'hFFFFFFFF, 1,
              reply(rha_pkg::ST_UNKNOWN, 0, 0, 0, 0)},
            '{rha_pkg::MODE_ALLOC, 16'd0,    32'd0,        1,
              reply(rha_pkg::ST_NOSPACE, 0, 0, 0, 0)},
            '{rha_pkg::MODE_ALLOC, 16'd100,  32'd0,        1,
              reply(rha_pkg::ST_OK, 1, 0, 0, 100)},
            '{rha_pkg::MODE_ALLOC, 16'd200,  32'd0,        1,
              reply(rha_pkg::ST_OK, 2, 0, 100, 200)},
            '{rha_pkg::MODE_ALLOC, 16'd300,  32'd0,        0, '0},
            '{rha_pkg::MODE_RETR,  16'd0,    32'd2,        1,
              reply(rha_pkg::ST_OK, 0, 0, 100, 0)},
            '{rha_pkg::MODE_ADD,   16'd0,    32'd1,        0, '0},
            '{rha_pkg::MODE_DROP,  16'd0,    32'd2,        0, '0},
            '{rha_pkg::MODE_RETR,  16'd0,    32'd2,        1,
              reply(rha_pkg::ST_UNKNOWN, 0, 0, 0, 0)},
            '{rha_pkg::MODE_DROP,  16'd0,    32'd1,        0, '0},
            '{rha_pkg::MODE_RETR,  16'd0,    32'd1,        0, '0},
            '{rha_pkg::MODE_ALLOC, 16'hFFFF, 32'd0,        0, '0},
            '{rha_pkg::MODE_RETR,  16'd0,    32'd3,        0, '0},
            '{rha_pkg::MODE_ALLOC, 16'hFF00, 32'd0,        0, '0},
            '{rha_pkg::MODE_ALLOC, 16'd1,    32'd0,        0, '0},
            '{rha_pkg::MODE_DROP,  16'd0,    32'd1,        0, '0},
            '{rha_pkg::MODE_DROP,  16'd0,    32'd3,        0, '0}
        };
        foreach (dir_rows[i])
            issue(dir_rows[i].mode, dir_rows[i].size, dir_rows[i].handle,
                  dir_rows[i].chk, dir_rows[i].exp);
        drain();

        // saturate a count: add 0xFFFF times is too slow, so push the
        // table to full instead and hit the exhausted-table reply
        while (tbl_live < NOBJ)
            issue(rha_pkg::MODE_ALLOC, 16'($urandom_range(1, 1500)), 0);
        issue(rha_pkg::MODE_ALLOC, 16'd5, 0, 1, reply(rha_pkg::ST_FULL, 0, 0, 0, 0));
        // drop the oldest then force a full compaction of 31 entries
        issue(rha_pkg::MODE_DROP, 0, tbl_handle[0]);
        issue(rha_pkg::MODE_ALLOC, 16'hFFF0, 0);
        // pause until everything has come back
        drain();

        // random bursts
        while (n_items < 120) begin
            burst = $urandom_range(1, 12);
            repeat (burst) begin
                md = 2'($urandom_range(0, 3));
                if (tbl_live > 20 && md == rha_pkg::MODE_ALLOC)
                    md = rha_pkg::MODE_DROP;
                issue(md, (md == rha_pkg::MODE_ALLOC) ? pick_size() : 16'($urandom),
                      (md == rha_pkg::MODE_ALLOC) ? 32'($urandom) : pick_handle());
            end
            if ($urandom_range(0, 2) != 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
        end
        drain();

        $display("covered %0d requests, %0d results, %0d copies over %0d compactions",
                 n_items, n_results, n_copies, n_compactions);
        if (errors == 0 && pending_results.size() == 0)
            $display("refcounted_handle_allocator regression: pass");
        else
            $display("refcounted_handle_allocator regression: fail");
        $finish;
    end
endmodule
`default_nettype wire

@@ sim.f @@
+incdir+src
src/rha_pkg.sv
src/rha_cell.sv
src/refcounted_handle_allocator.sv
src/rha_checker.sv
sim/tb.sv
